### rtl/core/rrts_pkg.sv
// Shared types, codes and constants of the round-robin task scheduler.
package rrts_pkg;

  // Default scheduler capacity: admission queue, run ring and finished stack depth.
  localparam int unsigned MAX_TASKS_DEFAULT = 16;

  // Field widths.
  localparam int unsigned ID_W   = 16;
  localparam int unsigned TIME_W = 24;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned TASK_W = ID_W + TIME_W;

  // Reset value of the time quantum register.
  localparam logic [TIME_W-1:0] QUANTUM_RST = TIME_W'(1);

  // Action codes of an input item.
  localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_UNLOAD = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TICK   = 2'd2;

  // Report kinds of a result item.
  localparam logic [KIND_W-1:0] KIND_PROC     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_IDLE     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_UNLOADED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REJECT   = 3'd4;

  // What a chain cell loads on the next clock.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PREV,
    CELL_NEXT
  } cell_mode_e;

  // One task as held in the admission queue and the run ring.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] tm;
  } task_t;

  // One result item.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] tm;
  } result_t;

  // Admission queue status seen by the sequencer.
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

endpackage

### rtl/core/round_robin_task_scheduler_top.sv
// Top level of the round-robin task scheduler with a configurable time quantum.
//
// Input channel (in_valid_i / in_stall_o) carries one item: an action code with a
// task id and a task time. A load queues the task in the admission queue and gives
// no result unless the queue is full. An unload pops the finished-id stack. A tick
// retires a front task with no time left, admits one queued task at the ring front,
// then charges the back task one quantum, reports it and rotates it to the front.
// Output channel (out_valid_o / out_stall_i) carries at most one result per item.
// Loads and unloads act at acceptance. A tick runs as the retire at acceptance,
// the admit step (fed by the queue memory's registered read) and the charge and
// rotate step. The run ring and the finished stack are chains of cells that shift
// by one place per step; the back task is picked out of the ring in the admit
// step. The output register and one holding register let an item be accepted
// while a result waits; a result that finds the output register occupied waits in
// the holding register, and input stalls until the receiver takes the waiting
// result. The time quantum resets to one; the user writes it through cfg_we_i /
// cfg_wdata_i only while the block is idle, which the block does not enforce.
// Reset clears all counts; no clearing pass is needed.
module round_robin_task_scheduler_top #(
  parameter int unsigned MAX_TASKS = rrts_pkg::MAX_TASKS_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write port.
  input  logic                        cfg_we_i,
  input  logic [rrts_pkg::TIME_W-1:0] cfg_wdata_i,
  // Input item channel.
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [rrts_pkg::ACT_W-1:0]  action_i,
  input  logic [rrts_pkg::ID_W-1:0]   task_id_i,
  input  logic [rrts_pkg::TIME_W-1:0] task_time_i,
  // Result item channel.
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rrts_pkg::KIND_W-1:0] report_kind_o,
  output logic [rrts_pkg::ID_W-1:0]   reported_id_o,
  output logic [rrts_pkg::TIME_W-1:0] remaining_time_o
);

  localparam int unsigned CntW = $clog2(MAX_TASKS + 1);

  // Sequencer states.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ADMIT  = 2'd1;
  localparam logic [1:0] S_ROTATE = 2'd2;
  localparam logic [1:0] S_HOLD   = 2'd3;

  logic [1:0] state_q, state_d;

  logic [rrts_pkg::TIME_W-1:0] quantum_q;

  logic in_acc, is_load, is_unload, is_tick;
  logic retire, admit, rotate, stack_push, stack_pop;

  rrts_pkg::task_t        ring_data [MAX_TASKS];
  logic [rrts_pkg::ID_W-1:0] stack_data [MAX_TASKS];
  logic [CntW-1:0]        ring_cnt_q, ring_cnt_d;
  logic [CntW-1:0]        stack_cnt_q, stack_cnt_d;

  rrts_pkg::task_t        fifo_rdata;
  rrts_pkg::fifo_status_t fifo_st;

  rrts_pkg::task_t        ring_back, back_q, ring_inject;
  logic [rrts_pkg::TIME_W:0]   diff;
  logic [rrts_pkg::TIME_W-1:0] charged_tm;

  logic              emit_valid, out_free;
  rrts_pkg::result_t emit, out_q, hold_q;
  logic              out_valid_q, out_valid_d;

  // Item acceptance and decoding.
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_load    = in_acc && (action_i == rrts_pkg::ACT_LOAD);
  assign is_unload  = in_acc && (action_i == rrts_pkg::ACT_UNLOAD);
  assign is_tick    = in_acc && (action_i == rrts_pkg::ACT_TICK);

  // Time quantum register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= rrts_pkg::QUANTUM_RST;
    end else if (cfg_we_i) begin
      quantum_q <= cfg_wdata_i;
    end
  end

  // Admission queue.
  rrts_fifo #(
    .DEPTH (MAX_TASKS)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (is_load && !fifo_st.full),
    .push_data_i ({task_id_i, task_time_i}),
    .pop_i       (admit),
    .rd_data_o   (fifo_rdata),
    .status_o    (fifo_st)
  );

  // Ring and stack operations; each of the two does at most one per sequencer step.
  assign retire     = is_tick && (ring_cnt_q != '0) && (ring_data[0].tm == '0);
  assign stack_push = retire && (stack_cnt_q != CntW'(MAX_TASKS));
  assign stack_pop  = is_unload && (stack_cnt_q != '0);
  assign admit      = (state_q == S_ADMIT) && !fifo_st.empty
                      && (ring_cnt_q != CntW'(MAX_TASKS));
  assign rotate     = (state_q == S_ROTATE) && (ring_cnt_q != '0);

  always_comb begin
    ring_cnt_d  = ring_cnt_q;
    stack_cnt_d = stack_cnt_q;
    if (retire) begin
      ring_cnt_d = ring_cnt_q - CntW'(1);
    end else if (admit) begin
      ring_cnt_d = ring_cnt_q + CntW'(1);
    end
    if (stack_push) begin
      stack_cnt_d = stack_cnt_q + CntW'(1);
    end else if (stack_pop) begin
      stack_cnt_d = stack_cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_cnt_q  <= '0;
      stack_cnt_q <= '0;
    end else begin
      ring_cnt_q  <= ring_cnt_d;
      stack_cnt_q <= stack_cnt_d;
    end
  end

  // Pick the back task; after admission into an empty ring it is the admitted one.
  always_comb begin
    ring_back = '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (ring_cnt_q == CntW'(i + 1)) begin
        ring_back = ring_back | ring_data[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_ADMIT) begin
      back_q <= (ring_cnt_q == '0) ? fifo_rdata : ring_back;
    end
  end

  // Charge one quantum, saturating at zero.
  assign diff       = {1'b0, back_q.tm} - {1'b0, quantum_q};
  assign charged_tm = diff[rrts_pkg::TIME_W] ? '0 : diff[rrts_pkg::TIME_W-1:0];

  // The front cell takes the admitted task or the rotated back task.
  assign ring_inject = (state_q == S_ADMIT) ? fifo_rdata : {back_q.id, charged_tm};

  // Run ring: cell 0 is the front.
  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_ring
    localparam logic [CntW:0] Pos     = (CntW + 1)'(g);
    localparam logic [CntW:0] PosNext = (CntW + 1)'(g + 1);

    rrts_pkg::cell_mode_e mode;
    rrts_pkg::task_t      prev, next;
    logic [CntW:0]        cnt_ext;

    assign cnt_ext = {1'b0, ring_cnt_q};

    always_comb begin
      if (retire && (PosNext < cnt_ext)) begin
        mode = rrts_pkg::CELL_NEXT;
      end else if (admit && (Pos <= cnt_ext)) begin
        mode = rrts_pkg::CELL_PREV;
      end else if (rotate && (Pos < cnt_ext)) begin
        mode = rrts_pkg::CELL_PREV;
      end else begin
        mode = rrts_pkg::CELL_HOLD;
      end
    end

    if (g == 0) begin : g_first
      assign prev = ring_inject;
    end else begin : g_inner
      assign prev = ring_data[g-1];
    end
    if (g == MAX_TASKS - 1) begin : g_last
      assign next = '0;
    end else begin : g_mid
      assign next = ring_data[g+1];
    end

    rrts_cell #(
      .W (rrts_pkg::TASK_W)
    ) u_cell (
      .clk_i  (clk_i),
      .mode_i (mode),
      .prev_i (prev),
      .next_i (next),
      .data_o (ring_data[g])
    );
  end

  // Finished-id stack: cell 0 is the top.
  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_stack
    localparam logic [CntW:0] Pos     = (CntW + 1)'(g);
    localparam logic [CntW:0] PosNext = (CntW + 1)'(g + 1);

    rrts_pkg::cell_mode_e      mode;
    logic [rrts_pkg::ID_W-1:0] prev, next;
    logic [CntW:0]             cnt_ext;

    assign cnt_ext = {1'b0, stack_cnt_q};

    always_comb begin
      if (stack_push && (Pos <= cnt_ext)) begin
        mode = rrts_pkg::CELL_PREV;
      end else if (stack_pop && (PosNext < cnt_ext)) begin
        mode = rrts_pkg::CELL_NEXT;
      end else begin
        mode = rrts_pkg::CELL_HOLD;
      end
    end

    if (g == 0) begin : g_first
      assign prev = ring_data[0].id;
    end else begin : g_inner
      assign prev = stack_data[g-1];
    end
    if (g == MAX_TASKS - 1) begin : g_last
      assign next = '0;
    end else begin : g_mid
      assign next = stack_data[g+1];
    end

    rrts_cell #(
      .W (rrts_pkg::ID_W)
    ) u_cell (
      .clk_i  (clk_i),
      .mode_i (mode),
      .prev_i (prev),
      .next_i (next),
      .data_o (stack_data[g])
    );
  end

  // Result produced in this cycle, if any.
  always_comb begin
    emit_valid = 1'b0;
    emit       = '0;
    if (is_load && fifo_st.full) begin
      emit_valid = 1'b1;
      emit.kind  = rrts_pkg::KIND_REJECT;
    end else if (is_unload) begin
      emit_valid = 1'b1;
      if (stack_cnt_q != '0) begin
        emit.kind = rrts_pkg::KIND_UNLOADED;
        emit.id   = stack_data[0];
      end else begin
        emit.kind = rrts_pkg::KIND_EMPTY;
      end
    end else if (state_q == S_ROTATE) begin
      emit_valid = 1'b1;
      if (ring_cnt_q != '0) begin
        emit.kind = rrts_pkg::KIND_PROC;
        emit.id   = back_q.id;
        emit.tm   = charged_tm;
      end else begin
        emit.kind = rrts_pkg::KIND_IDLE;
      end
    end
  end

  // Output register with a holding register behind it.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = emit_valid || (state_q == S_HOLD);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && emit_valid) begin
      out_q <= emit;
    end else if (out_free && (state_q == S_HOLD)) begin
      out_q <= hold_q;
    end
    if (!out_free && emit_valid) begin
      hold_q <= emit;
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (is_tick) begin
          state_d = S_ADMIT;
        end else if (emit_valid && !out_free) begin
          state_d = S_HOLD;
        end
      end
      S_ADMIT:  state_d = S_ROTATE;
      S_ROTATE: state_d = out_free ? S_IDLE : S_HOLD;
      S_HOLD:   state_d = out_free ? S_IDLE : S_HOLD;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign report_kind_o    = out_q.kind;
  assign reported_id_o    = out_q.id;
  assign remaining_time_o = out_q.tm;

  // Ring and stack fill counts stay within capacity.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ring_cnt_q <= CntW'(MAX_TASKS)) && (stack_cnt_q <= CntW'(MAX_TASKS)))
    else $error("ring or stack count above capacity");

  // An accepted tick always proceeds to admission and then to the rotate step.
  a_tick_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_tick |=> (state_q == S_ADMIT) ##1 (state_q == S_ROTATE))
    else $error("tick sequence broken");

  // A held result only exists while the output register is occupied.
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HOLD) |-> out_valid_q)
    else $error("holding a result with an empty output register");

  // A held result moves out as soon as the receiver takes the waiting one.
  a_hold_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_HOLD) && !out_stall_i) |=> (state_q == S_IDLE) && out_valid_q)
    else $error("held result not forwarded");

endmodule

### rtl/core/rrts_cell.sv
// One storage cell of a shifting chain; it holds or takes a neighbor's value.
module rrts_cell #(
  parameter int unsigned W = rrts_pkg::ID_W
) (
  input  logic                   clk_i,
  input  rrts_pkg::cell_mode_e   mode_i,
  input  logic [W-1:0]           prev_i,
  input  logic [W-1:0]           next_i,
  output logic [W-1:0]           data_o
);

  logic [W-1:0] data_q, data_d;

  // Select the value to load: own, from the cell toward the front, or toward the back.
  always_comb begin
    unique case (mode_i)
      rrts_pkg::CELL_PREV: data_d = prev_i;
      rrts_pkg::CELL_NEXT: data_d = next_i;
      default:             data_d = data_q;
    endcase
  end

  // Payload register; contents are meaningful only below the owner's fill count.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### rtl/core/rrts_fifo.sv
// Admission queue: a circular buffer in a memory with a registered read port.
module rrts_fifo #(
  parameter int unsigned DEPTH = rrts_pkg::MAX_TASKS_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  rrts_pkg::task_t        push_data_i,
  input  logic                   pop_i,
  output rrts_pkg::task_t        rd_data_o,
  output rrts_pkg::fifo_status_t status_o
);

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  rrts_pkg::task_t mem [DEPTH];
  rrts_pkg::task_t rd_data_q;

  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  // Pointer and count update; push and pop never fall in the same cycle.
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(DEPTH - 1)) ? '0 : wr_ptr_q + AddrW'(1);
      cnt_d    = cnt_q + CntW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(DEPTH - 1)) ? '0 : rd_ptr_q + AddrW'(1);
      cnt_d    = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Memory write port and registered read of the queue head.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
    rd_data_q <= mem[rd_ptr_q];
  end

  assign rd_data_o      = rd_data_q;
  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == CntW'(DEPTH));

  // The count never passes the depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("admission count above depth");

  // The sequencer never pushes into a full queue or pops an empty one.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && status_o.full) && !(pop_i && status_o.empty))
    else $error("admission queue overrun or underrun");

endmodule

### test/tb_round_robin_task_scheduler_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the round-robin task scheduler top level.
module tb_round_robin_task_scheduler_top;

  localparam int unsigned DEPTH  = rrts_pkg::MAX_TASKS_DEFAULT;
  localparam int unsigned ID_W   = rrts_pkg::ID_W;
  localparam int unsigned TIME_W = rrts_pkg::TIME_W;
  localparam int unsigned KIND_W = rrts_pkg::KIND_W;
  localparam int unsigned ACT_W  = rrts_pkg::ACT_W;
  // Cycles to let a tick that is still in flight finish before a register write.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  // The one action code that the block ignores.
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [TIME_W-1:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_stall_o;
  logic [ACT_W-1:0] action_i;
  logic [ID_W-1:0] task_id_i;
  logic [TIME_W-1:0] task_time_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [KIND_W-1:0] report_kind_o;
  logic [ID_W-1:0] reported_id_o;
  logic [TIME_W-1:0] remaining_time_o;

  // Predicted scheduler state.
  logic [TIME_W-1:0] quantum;
  rrts_pkg::task_t admit_fifo [DEPTH];
  int unsigned admit_rd;
  int unsigned admit_cnt;
  rrts_pkg::task_t run_ring [DEPTH];
  int unsigned ring_cnt;
  logic [ID_W-1:0] done_ids [DEPTH];
  int unsigned done_cnt;

  // Reports still owed by the block, oldest first.
  rrts_pkg::result_t pending_reports [$];
  rrts_pkg::result_t want;
  int unsigned err_count = 0;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;

  round_robin_task_scheduler_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .task_id_i        (task_id_i),
    .task_time_i      (task_time_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .report_kind_o    (report_kind_o),
    .reported_id_o    (reported_id_o),
    .remaining_time_o (remaining_time_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void queue_report(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                       logic [TIME_W-1:0] tm);
    rrts_pkg::result_t r;
    r.kind = kind;
    r.id = id;
    r.tm = tm;
    pending_reports.push_back(r);
  endfunction

  function automatic void ring_insert_front(rrts_pkg::task_t t);
    int i;
    for (i = int'(ring_cnt); i > 0; i--) begin
      run_ring[i] = run_ring[i - 1];
    end
    run_ring[0] = t;
    ring_cnt++;
  endfunction

  // Advance the predicted state by one accepted item and queue its report.
  function automatic void schedule_step(logic [ACT_W-1:0] act, logic [ID_W-1:0] id,
                                        logic [TIME_W-1:0] tm);
    rrts_pkg::task_t cur;
    int i;
    case (act)
      rrts_pkg::ACT_LOAD: begin
        if (admit_cnt >= DEPTH) begin
          queue_report(rrts_pkg::KIND_REJECT, '0, '0);
        end else begin
          cur.id = id;
          cur.tm = tm;
          admit_fifo[(admit_rd + admit_cnt) % DEPTH] = cur;
          admit_cnt++;
        end
      end
      rrts_pkg::ACT_UNLOAD: begin
        if (done_cnt == 0) begin
          queue_report(rrts_pkg::KIND_EMPTY, '0, '0);
        end else begin
          done_cnt--;
          queue_report(rrts_pkg::KIND_UNLOADED, done_ids[done_cnt], '0);
        end
      end
      rrts_pkg::ACT_TICK: begin
        // Retire the front task once it has no time left; a full stack drops the id.
        if (ring_cnt > 0 && run_ring[0].tm == '0) begin
          cur = run_ring[0];
          for (i = 0; i + 1 < int'(ring_cnt); i++) begin
            run_ring[i] = run_ring[i + 1];
          end
          ring_cnt--;
          if (done_cnt < DEPTH) begin
            done_ids[done_cnt] = cur.id;
            done_cnt++;
          end
        end
        // Admit one queued task unless the ring is full.
        if (admit_cnt > 0 && ring_cnt < DEPTH) begin
          ring_insert_front(admit_fifo[admit_rd]);
          admit_rd = (admit_rd + 1) % DEPTH;
          admit_cnt--;
        end
        // Charge the back task, saturating at zero, and rotate it to the front.
        if (ring_cnt == 0) begin
          queue_report(rrts_pkg::KIND_IDLE, '0, '0);
        end else begin
          cur = run_ring[ring_cnt - 1];
          cur.tm = (cur.tm >= quantum) ? cur.tm - quantum : '0;
          ring_cnt--;
          ring_insert_front(cur);
          queue_report(rrts_pkg::KIND_PROC, cur.id, cur.tm);
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Task times: mostly short or a multiple of the quantum, some fully random.
  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 3))
      0: return TIME_W'($urandom_range(0, 4));
      1: return TIME_W'($urandom);
      2: return TIME_W'(quantum * $urandom_range(1, 3));
      default: return TIME_W'($urandom_range(0, 64));
    endcase
  endfunction

  // Offer one item after a random gap and hold it until the block takes it.
  task automatic send_item(logic [ACT_W-1:0] act, logic [ID_W-1:0] id,
                           logic [TIME_W-1:0] tm);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) begin
      in_burst = !in_burst;
    end
    gap = in_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    task_id_i <= id;
    task_time_i <= tm;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    schedule_step(act, id, tm);
  endtask

  // Stop sending and wait until every owed report has been taken.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  // Write the time quantum once the block has gone quiet.
  task automatic set_quantum(logic [TIME_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    quantum = value;
  endtask

  // Random mix of loads and ticks; unloads and ignored codes fill the rest.
  task automatic run_random_mix(int unsigned n_items, int unsigned load_w,
                                int unsigned tick_w);
    int unsigned sent;
    int unsigned r;
    logic [ACT_W-1:0] act;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < load_w) begin
        act = rrts_pkg::ACT_LOAD;
      end else if (r < load_w + tick_w) begin
        act = rrts_pkg::ACT_TICK;
      end else if (r < 97) begin
        act = rrts_pkg::ACT_UNLOAD;
      end else begin
        act = ACT_NONE;
      end
      send_item(act, ID_W'($urandom),
                (act == rrts_pkg::ACT_LOAD) ? pick_time() : TIME_W'($urandom));
      if (act != ACT_NONE) begin
        sent++;
      end
    end
  endtask

  // Every action, idle and empty cases, field extremes and saturation.
  task automatic test_directed_cases();
    send_item(rrts_pkg::ACT_UNLOAD, '0, '0);
    send_item(rrts_pkg::ACT_TICK, '0, '0);
    send_item(ACT_NONE, '1, TIME_MAX);
    send_item(rrts_pkg::ACT_LOAD, '1, TIME_MAX);
    send_item(rrts_pkg::ACT_LOAD, '0, '0);
    send_item(rrts_pkg::ACT_LOAD, 16'h1234, 24'd1);
    repeat (4) send_item(rrts_pkg::ACT_TICK, '0, '0);
    send_item(rrts_pkg::ACT_UNLOAD, '0, '0);
    send_item(rrts_pkg::ACT_UNLOAD, '0, '0);
    // A charge far larger than any time left saturates at zero.
    set_quantum(TIME_MAX);
    repeat (3) send_item(rrts_pkg::ACT_TICK, '1, TIME_MAX);
    repeat (3) send_item(rrts_pkg::ACT_UNLOAD, '0, '0);
  endtask

  // Fill the admission queue and the ring until loads are rejected and admission stalls.
  task automatic test_queue_overflow();
    set_quantum(rrts_pkg::QUANTUM_RST);
    repeat (DEPTH + 1) begin
      send_item(rrts_pkg::ACT_LOAD, ID_W'($urandom),
                TIME_W'($urandom_range(4096, 24'hFFFFFF)));
    end
    repeat (DEPTH + 4) send_item(rrts_pkg::ACT_TICK, '0, '0);
    repeat (DEPTH + 1) begin
      send_item(rrts_pkg::ACT_LOAD, ID_W'($urandom),
                TIME_W'($urandom_range(4096, 24'hFFFFFF)));
    end
    repeat (6) send_item(rrts_pkg::ACT_TICK, '0, '0);
  endtask

  // Retire more tasks than the stack holds, then unload past the bottom.
  task automatic test_stack_overflow();
    set_quantum(TIME_MAX);
    repeat (5 * DEPTH) send_item(rrts_pkg::ACT_TICK, '0, '0);
    repeat (DEPTH + 3) send_item(rrts_pkg::ACT_UNLOAD, '0, '0);
  endtask

  // Long random runs under the quantum extremes and a few values in between.
  task automatic test_random_quanta();
    set_quantum('0);
    run_random_mix(220, 40, 45);
    set_quantum(TIME_MAX);
    run_random_mix(220, 45, 40);
    set_quantum(TIME_W'($urandom_range(1, 16)));
    run_random_mix(260, 55, 35);
    set_quantum(TIME_W'($urandom));
    run_random_mix(220, 35, 50);
    set_quantum(rrts_pkg::QUANTUM_RST);
    run_random_mix(220, 40, 45);
  endtask

  // Short bursts, each followed by a pause until the block has answered everything.
  task automatic test_pause_until_drained();
    set_quantum(TIME_W'(2));
    repeat (12) begin
      run_random_mix($urandom_range(1, 20), 40, 45);
      wait_drained();
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    action_i <= rrts_pkg::ACT_LOAD;
    task_id_i <= '0;
    task_time_i <= '0;
    quantum = rrts_pkg::QUANTUM_RST;
    admit_rd = 0;
    admit_cnt = 0;
    ring_cnt = 0;
    done_cnt = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_queue_overflow();
    test_stack_overflow();
    test_random_quanta();
    test_pause_until_drained();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (err_count == 0 && pending_reports.size() == 0) begin
      $display("round_robin_task_scheduler_top test passed");
    end else begin
      $display("round_robin_task_scheduler_top test failed");
    end
    $finish;
  end

  // Receiver: after each taken item, stall for a random number of cycles.
  initial begin : result_receiver
    int unsigned hold;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      while (!(rst_ni && out_valid_o && !out_stall_i)) @(posedge clk_i);
      if ($urandom_range(0, 39) == 0) begin
        out_burst = !out_burst;
      end
      hold = out_burst ? 0 : $urandom_range(0, 12);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each taken result with the oldest owed report.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: result with none owed: kind %0d id %0d time %0d", $time,
                 report_kind_o, reported_id_o, remaining_time_o);
        err_count++;
      end else begin
        want = pending_reports.pop_front();
        if (report_kind_o !== want.kind) begin
          $display("%0t: report_kind expected %0d actual %0d", $time, want.kind,
                   report_kind_o);
          err_count++;
        end
        if (reported_id_o !== want.id) begin
          $display("%0t: reported_id expected %0d actual %0d", $time, want.id,
                   reported_id_o);
          err_count++;
        end
        if (remaining_time_o !== want.tm) begin
          $display("%0t: remaining_time expected %0d actual %0d", $time, want.tm,
                   remaining_time_o);
          err_count++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  initial begin
    #6_000_000;
    $display("round_robin_task_scheduler_top test failed");
    $finish;
  end

endmodule
